FILE: sv/tsa_pkg.sv
// Package for the tagged slot allocator: sizes, command and status codes,
// controller states and the layout of one slot memory word.
// No dependencies.
package tsa_pkg;

   localparam int SLOT_BITS = 12;
   localparam int GEN_BITS  = 32 - SLOT_BITS;
   localparam int TAG_BITS  = GEN_BITS + SLOT_BITS;
   localparam int EXTRA_W   = 32;

   // free count runs 0 .. NSLOTS, hence one extra bit
   localparam logic [SLOT_BITS:0] NSLOTS = {1'b1, {SLOT_BITS{1'b0}}};

   // command codes
   localparam logic [1:0] CMD_ALLOC    = 2'd0;
   localparam logic [1:0] CMD_ARM      = 2'd1;
   localparam logic [1:0] CMD_COMPLETE = 2'd2;

   // status codes
   localparam logic [2:0] ST_ALLOCATED = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_DELIVERED = 3'd2;
   localparam logic [2:0] ST_STALE     = 3'd3;
   localparam logic [2:0] ST_NOWAITER  = 3'd4;
   localparam logic [2:0] ST_TIMEOUT   = 3'd5;
   localparam logic [2:0] ST_ARMED     = 3'd6;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_POP,
      FSM_EXEC
   } fsm_type;

   typedef struct packed {
      logic [GEN_BITS-1:0] gen;
      logic                waiter;
      logic [EXTRA_W-1:0]  extra;
   } slot_word_type;

   localparam int SLOT_WORD_W = $bits(slot_word_type);

endpackage

FILE: sv/tsa_ram.sv
// Simple dual-port synchronous RAM, one write and one read port,
// registered read data. No dependencies.
module tsa_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/tagged_slot_allocator.sv
// Tagged slot allocator, top level.
// Depends on tsa_pkg and tsa_ram.
//
// Usage:
//  Request channel (req_*): one word per command. Allocate pops a slot off a
//  LIFO free stack, bumps its generation, stores req_extra_in and returns
//  the tag {generation, slot}. Arm sets the waiter flag of req_slot_index.
//  Complete checks the tag in req_done_tag and, when it is current and
//  armed, delivers result and extra word and returns the slot to the stack.
//  Command 3 is ignored and yields no response word.
//  Response channel (rsp_*): one word per allocate, arm or complete.
//  Sequencing: arm and complete read the slot RAM, then modify and write
//  it; allocate reads the free stack, then reads and writes the slot RAM,
//  skipping the stack read on an empty pool. One command at a time; the
//  next is taken the cycle after the result moves to the output register.
//  Reset: a clearing sweep zeroes the slot RAM (generation, waiter) at one
//  entry per cycle, with req_stall high throughout. The free stack needs
//  no sweep: entries below the lowest free count seen since reset have
//  never been written and read as their own index.
//  Stall: a result waits in the output register while rsp_stall is high;
//  a second finished result waits in the pipeline until the register frees.
module tagged_slot_allocator (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_cmd,
   input  logic [11:0]         req_slot_index,
   input  logic signed [31:0]  req_extra_in,
   input  logic [63:0]         req_done_tag,
   input  logic signed [31:0]  req_result_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_tag,
   output logic [11:0]         rsp_slot_out,
   output logic signed [31:0]  rsp_result_out,
   output logic signed [31:0]  rsp_extra_out
);

   localparam int SB = tsa_pkg::SLOT_BITS;
   localparam int GB = tsa_pkg::GEN_BITS;

   // controller state
   tsa_pkg::fsm_type state_ff, state_in;
   logic [SB-1:0]    clr_ff, clr_in;      // clearing sweep address
   logic [SB:0]      fc_ff, fc_in;        // free count
   logic [SB:0]      lw_ff, lw_in;        // lowest free count since reset

   // latched command word
   logic [1:0]       cmd_ff, cmd_in;
   logic [SB-1:0]    idx_ff, idx_in;
   logic [31:0]      extra_ff, extra_in;
   logic [31:0]      ud_ff, ud_in;        // low half of the tag
   logic             timeout_ff, timeout_in;
   logic [31:0]      result_ff, result_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [31:0]      rsp_tag_ff, rsp_tag_in;
   logic [11:0]      rsp_slot_ff, rsp_slot_in;
   logic [31:0]      rsp_result_ff, rsp_result_in;
   logic [31:0]      rsp_extra_ff, rsp_extra_in;

   // memory ports
   logic                          slot_we, slot_re;
   logic [SB-1:0]                 slot_wa, slot_ra;
   tsa_pkg::slot_word_type        slot_wd, slot_rd;
   logic [tsa_pkg::SLOT_WORD_W-1:0] slot_rd_raw;
   logic                          stack_we, stack_re;
   logic [SB-1:0]                 stack_wa, stack_ra, stack_wd, stack_rd;

   logic             out_free;
   logic             rsp_load;
   logic [SB:0]      fc_dec;
   logic [SB-1:0]    pop_pos;
   logic [SB-1:0]    popped_idx;
   logic [GB-1:0]    gen_new;

   tsa_ram #(
      .WIDTH     (tsa_pkg::SLOT_WORD_W),
      .ADDR_BITS (SB)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_wa),
      .wr_data (slot_wd),
      .rd_en   (slot_re),
      .rd_addr (slot_ra),
      .rd_data (slot_rd_raw)
   );

   assign slot_rd = tsa_pkg::slot_word_type'(slot_rd_raw);

   tsa_ram #(
      .WIDTH     (SB),
      .ADDR_BITS (SB)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_wa),
      .wr_data (stack_wd),
      .rd_en   (stack_re),
      .rd_addr (stack_ra),
      .rd_data (stack_rd)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign fc_dec     = fc_ff - 1'b1;
   assign pop_pos    = fc_dec[SB-1:0];
   // untouched stack entries read as their own index
   assign popped_idx = ({1'b0, pop_pos} < lw_ff) ? pop_pos : stack_rd;
   assign gen_new    = slot_rd.gen + 1'b1;

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      fc_in      = fc_ff;
      lw_in      = lw_ff;
      cmd_in     = cmd_ff;
      idx_in     = idx_ff;
      extra_in   = extra_ff;
      ud_in      = ud_ff;
      timeout_in = timeout_ff;
      result_in  = result_ff;

      slot_we  = 1'b0;
      slot_wa  = idx_ff;
      slot_wd  = '0;
      slot_re  = 1'b0;
      slot_ra  = idx_ff;
      stack_we = 1'b0;
      stack_wa = fc_ff[SB-1:0];
      stack_wd = idx_ff;
      stack_re = 1'b0;
      stack_ra = pop_pos;

      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_result_in = rsp_result_ff;
      rsp_extra_in  = rsp_extra_ff;

      unique case (state_ff)
         tsa_pkg::FSM_CLEAR: begin
            slot_we = 1'b1;
            slot_wa = clr_ff;
            slot_wd = '0;
            clr_in  = clr_ff + 1'b1;
            if (&clr_ff) begin
               state_in = tsa_pkg::FSM_IDLE;
            end
         end
         tsa_pkg::FSM_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               extra_in   = req_extra_in;
               ud_in      = req_done_tag[31:0];
               timeout_in = &req_done_tag;
               result_in  = req_result_value;
               unique case (req_cmd)
                  tsa_pkg::CMD_ALLOC: begin
                     if (fc_ff == '0) begin
                        state_in = tsa_pkg::FSM_EXEC;
                     end else begin
                        stack_re = 1'b1;
                        state_in = tsa_pkg::FSM_POP;
                     end
                  end
                  tsa_pkg::CMD_ARM: begin
                     idx_in   = req_slot_index[SB-1:0];
                     slot_re  = 1'b1;
                     slot_ra  = req_slot_index[SB-1:0];
                     state_in = tsa_pkg::FSM_EXEC;
                  end
                  tsa_pkg::CMD_COMPLETE: begin
                     idx_in   = req_done_tag[SB-1:0];
                     slot_re  = 1'b1;
                     slot_ra  = req_done_tag[SB-1:0];
                     state_in = tsa_pkg::FSM_EXEC;
                  end
                  default: begin
                     state_in = tsa_pkg::FSM_IDLE;
                  end
               endcase
            end
         end
         tsa_pkg::FSM_POP: begin
            idx_in   = popped_idx;
            slot_re  = 1'b1;
            slot_ra  = popped_idx;
            state_in = tsa_pkg::FSM_EXEC;
         end
         tsa_pkg::FSM_EXEC: begin
            if (out_free) begin
               state_in      = tsa_pkg::FSM_IDLE;
               rsp_load      = 1'b1;
               rsp_tag_in    = '0;
               rsp_slot_in   = '0;
               rsp_result_in = '0;
               rsp_extra_in  = '0;
               unique case (cmd_ff)
                  tsa_pkg::CMD_ALLOC: begin
                     if (fc_ff == '0) begin
                        rsp_status_in = tsa_pkg::ST_EMPTY;
                     end else begin
                        slot_we        = 1'b1;
                        slot_wd.gen    = gen_new;
                        slot_wd.waiter = 1'b0;
                        slot_wd.extra  = extra_ff;
                        fc_in          = fc_dec;
                        if (fc_dec < lw_ff) begin
                           lw_in = fc_dec;
                        end
                        rsp_status_in = tsa_pkg::ST_ALLOCATED;
                        rsp_tag_in    = {gen_new, idx_ff};
                        rsp_slot_in   = 12'(idx_ff);
                        rsp_extra_in  = extra_ff;
                     end
                  end
                  tsa_pkg::CMD_ARM: begin
                     slot_we        = 1'b1;
                     slot_wd        = slot_rd;
                     slot_wd.waiter = 1'b1;
                     rsp_status_in  = tsa_pkg::ST_ARMED;
                     rsp_slot_in    = 12'(idx_ff);
                  end
                  default: begin
                     // completion
                     if (timeout_ff) begin
                        rsp_status_in = tsa_pkg::ST_TIMEOUT;
                     end else if (slot_rd.gen != ud_ff[31:SB]) begin
                        rsp_status_in = tsa_pkg::ST_STALE;
                        rsp_slot_in   = 12'(idx_ff);
                     end else if (!slot_rd.waiter) begin
                        rsp_status_in = tsa_pkg::ST_NOWAITER;
                        rsp_slot_in   = 12'(idx_ff);
                     end else begin
                        slot_we        = 1'b1;
                        slot_wd        = slot_rd;
                        slot_wd.waiter = 1'b0;
                        // push dropped when the stack is already full
                        if (fc_ff != tsa_pkg::NSLOTS) begin
                           stack_we = 1'b1;
                           fc_in    = fc_ff + 1'b1;
                        end
                        rsp_status_in = tsa_pkg::ST_DELIVERED;
                        rsp_slot_in   = 12'(idx_ff);
                        rsp_result_in = result_ff;
                        rsp_extra_in  = slot_rd.extra;
                     end
                  end
               endcase
            end
         end
         default: begin
            state_in = tsa_pkg::FSM_IDLE;
         end
      endcase

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tsa_pkg::FSM_CLEAR;
         clr_ff       <= '0;
         fc_ff        <= tsa_pkg::NSLOTS;
         lw_ff        <= tsa_pkg::NSLOTS;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         fc_ff        <= fc_in;
         lw_ff        <= lw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      extra_ff      <= extra_in;
      ud_ff         <= ud_in;
      timeout_ff    <= timeout_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_result_ff <= rsp_result_in;
      rsp_extra_ff  <= rsp_extra_in;
   end

   assign req_stall      = (state_ff != tsa_pkg::FSM_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_tag        = rsp_tag_ff;
   assign rsp_slot_out   = rsp_slot_ff;
   assign rsp_result_out = rsp_result_ff;
   assign rsp_extra_out  = rsp_extra_ff;

`ifndef SYNTHESIS
   a_fc_range: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= tsa_pkg::NSLOTS)
      else $error("free count above slot count");

   a_low_water: assert property (@(posedge clock) disable iff (reset)
      lw_ff <= fc_ff)
      else $error("low-water mark above free count");

   a_alloc_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && cmd_ff == tsa_pkg::CMD_ALLOC && fc_ff != '0)
      |=> (fc_ff + 1'b1) == $past(fc_ff))
      else $error("allocation did not pop the free stack");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tsa_pkg::FSM_EXEC))
      else $error("response loaded outside execute");

   a_no_rsp_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tsa_pkg::FSM_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing sweep");
`endif

endmodule

FILE: tb/tsa_checker.sv
`timescale 1ns / 1ps
// Reply checker for the tagged slot allocator: follows the slot pool on every
// accepted request word and compares each reply word with its prediction.
// Depends on tsa_pkg.
module tsa_checker
   import tsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [1:0]           req_cmd,
   input  logic [SLOT_BITS-1:0] req_slot_index,
   input  logic [EXTRA_W-1:0]   req_extra_in,
   input  logic [63:0]          req_done_tag,
   input  logic [31:0]          req_result_value,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [2:0]           rsp_status,
   input  logic [TAG_BITS-1:0]  rsp_tag,
   input  logic [SLOT_BITS-1:0] rsp_slot_out,
   input  logic [31:0]          rsp_result_out,
   input  logic [EXTRA_W-1:0]   rsp_extra_out,
   output int                   failures,
   output int                   outstanding,
   output int                   checked
);

   localparam int DEPTH = 1 << SLOT_BITS;

   typedef struct packed {
      logic [2:0]           status;
      logic [TAG_BITS-1:0]  tag;
      logic [SLOT_BITS-1:0] slot;
      logic [31:0]          result;
      logic [EXTRA_W-1:0]   extra;
   } reply_type;

   // own copy of the pool
   logic [SLOT_BITS-1:0] free_slots [DEPTH];
   logic [SLOT_BITS:0]   free_level;
   logic [GEN_BITS-1:0]  slot_gen   [DEPTH];
   logic                 slot_armed [DEPTH];
   logic [EXTRA_W-1:0]   slot_extra [DEPTH];
   reply_type            replies_due [$];

   function automatic reply_type resolve_command(input logic [1:0] cmd,
                                                 input logic [SLOT_BITS-1:0] arm_slot,
                                                 input logic [EXTRA_W-1:0] extra,
                                                 input logic [63:0] done_tag,
                                                 input logic [31:0] result);
      reply_type r;
      logic [SLOT_BITS-1:0] idx;
      logic [GEN_BITS-1:0] g;
      r = '0;
      case (cmd)
         CMD_ALLOC: begin
            if (free_level == '0) begin
               r.status = ST_EMPTY;
            end else begin
               free_level = free_level - 1'b1;
               idx = free_slots[free_level[SLOT_BITS-1:0]];
               g = slot_gen[idx] + 1'b1;
               slot_gen[idx] = g;
               slot_armed[idx] = 1'b0;
               slot_extra[idx] = extra;
               r.status = ST_ALLOCATED;
               r.tag = {g, idx};
               r.slot = idx;
               r.extra = extra;
            end
         end
         CMD_ARM: begin
            slot_armed[arm_slot] = 1'b1;
            r.status = ST_ARMED;
            r.slot = arm_slot;
         end
         default: begin
            if (&done_tag) begin
               r.status = ST_TIMEOUT;
            end else begin
               // only the low tag bits count
               idx = done_tag[SLOT_BITS-1:0];
               g = done_tag[TAG_BITS-1:SLOT_BITS];
               r.slot = idx;
               if (slot_gen[idx] != g) begin
                  r.status = ST_STALE;
               end else if (!slot_armed[idx]) begin
                  r.status = ST_NOWAITER;
               end else begin
                  slot_armed[idx] = 1'b0;
                  // push onto a full stack is lost
                  if (free_level < NSLOTS) begin
                     free_slots[free_level[SLOT_BITS-1:0]] = idx;
                     free_level = free_level + 1'b1;
                  end
                  r.status = ST_DELIVERED;
                  r.result = result;
                  r.extra = slot_extra[idx];
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch_words
      reply_type want;
      logic bad;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            free_slots[i] = SLOT_BITS'(i);
            slot_gen[i] = '0;
            slot_armed[i] = 1'b0;
            slot_extra[i] = '0;
         end
         free_level = NSLOTS;
         replies_due.delete();
         failures = 0;
         checked = 0;
      end else begin
         // reply first: a request word cannot be answered in its own cycle
         if (rsp_valid && !rsp_stall) begin
            if (replies_due.size() == 0) begin
               $display("%0t ns: reply word with none expected, status %0d tag %h",
                        $time, rsp_status, rsp_tag);
               failures++;
            end else begin
               want = replies_due.pop_front();
               bad = 1'b0;
               if (rsp_status !== want.status) begin
                  $display("%0t ns: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
                  bad = 1'b1;
               end
               if (rsp_tag !== want.tag) begin
                  $display("%0t ns: tag expected %h, got %h", $time, want.tag, rsp_tag);
                  bad = 1'b1;
               end
               if (rsp_slot_out !== want.slot) begin
                  $display("%0t ns: slot expected %0d, got %0d",
                           $time, want.slot, rsp_slot_out);
                  bad = 1'b1;
               end
               if (rsp_result_out !== want.result) begin
                  $display("%0t ns: result expected %h, got %h",
                           $time, want.result, rsp_result_out);
                  bad = 1'b1;
               end
               if (rsp_extra_out !== want.extra) begin
                  $display("%0t ns: extra expected %h, got %h",
                           $time, want.extra, rsp_extra_out);
                  bad = 1'b1;
               end
               if (bad) failures++;
               checked++;
            end
         end
         // command 3 gives no reply
         if (req_valid && !req_stall && req_cmd <= CMD_COMPLETE)
            replies_due.insert(replies_due.size(),
                               resolve_command(req_cmd, req_slot_index, req_extra_in,
                                               req_done_tag, req_result_value));
      end
      outstanding <= replies_due.size();
   end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the tagged slot allocator testbench: clock, reset, request words
// and reply stalls; the verdict comes from the count kept by tsa_checker.
// Depends on tsa_pkg, tsa_checker and tagged_slot_allocator.
module testbench;
   import tsa_pkg::*;

   // unused command code, must be swallowed without a reply
   localparam logic [1:0] CMD_NONE = 2'd3;
   localparam int RANDOM_WORDS = 1630;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_cmd;
   logic [SLOT_BITS-1:0] req_slot_index;
   logic signed [31:0]   req_extra_in;
   logic [63:0]          req_done_tag;
   logic signed [31:0]   req_result_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [2:0]           rsp_status;
   logic [31:0]          rsp_tag;
   logic [SLOT_BITS-1:0] rsp_slot_out;
   logic signed [31:0]   rsp_result_out;
   logic signed [31:0]   rsp_extra_out;

   int fail_count;
   int pending_replies;
   int replies_checked;

   // what the stimulus knows of the pool, learnt from reply words
   logic [TAG_BITS-1:0] live_tags [$];
   bit   seen_alloc [1 << SLOT_BITS];

   int n_sent, n_replies, n_alloc, n_empty, n_delivered, n_stale, n_nowaiter,
       n_timeout;
   bit calm_req, calm_rsp;
   int rsp_hold;

   tagged_slot_allocator dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot_index   (req_slot_index),
      .req_extra_in     (req_extra_in),
      .req_done_tag     (req_done_tag),
      .req_result_value (req_result_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tag          (rsp_tag),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_result_out   (rsp_result_out),
      .rsp_extra_out    (rsp_extra_out)
   );

   tsa_checker tracker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_slot_index   (req_slot_index),
      .req_extra_in     (req_extra_in),
      .req_done_tag     (req_done_tag),
      .req_result_value (req_result_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_tag          (rsp_tag),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_result_out   (rsp_result_out),
      .rsp_extra_out    (rsp_extra_out),
      .failures         (fail_count),
      .outstanding      (pending_replies),
      .checked          (replies_checked)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // Hard stop. The slowest legal run (every gap and stall at its longest,
   // ~1.7k words, plus the clearing sweep) is well under a tenth of this.
   initial begin
      #(64'd20_000_000);
      $display("CHECK FAILED");
      $finish;
   end

   // Mostly random extra/result words, with the extremes now and then.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // A slot never allocated still has generation zero, and delivering from
   // it would read an extra word that was never stored. Bump the generation
   // field of such tags so they can only be stale.
   function automatic logic [63:0] safe_tag(input logic [63:0] done_tag);
      logic [63:0] u;
      u = done_tag;
      if (u[TAG_BITS-1:SLOT_BITS] == '0 && !seen_alloc[u[SLOT_BITS-1:0]])
         u[SLOT_BITS] = 1'b1;
      return u;
   endfunction

   // One request word. Called at a rising edge; returns at the edge that
   // accepted the word, with valid still high so back-to-back words need
   // no second assignment in the same step.
   task automatic send_word(input logic [1:0] cmd, input logic [SLOT_BITS-1:0] slot,
                            input logic [31:0] extra, input logic [63:0] done_tag,
                            input logic [31:0] result);
      int gap;
      gap = calm_req ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_slot_index   <= slot;
      req_extra_in     <= extra;
      req_done_tag     <= done_tag;
      req_result_value <= result;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      n_sent++;
      // quiet stretches: roughly one block in four goes without gaps
      if (n_sent % 64 == 0) calm_req = ($urandom_range(0, 3) == 0);
   endtask

   // Sender holds off until every reply word has come back.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_replies != 0) @(posedge clock);
   endtask

   // Arm the slot of one live tag, then complete it: the well-formed path.
   task automatic arm_and_complete();
      int pick;
      logic [TAG_BITS-1:0] tag;
      pick = $urandom_range(0, live_tags.size() - 1);
      tag = live_tags[pick];
      live_tags.delete(pick);
      send_word(CMD_ARM, tag[SLOT_BITS-1:0], $urandom, {$urandom, $urandom}, $urandom);
      send_word(CMD_COMPLETE, SLOT_BITS'($urandom), $urandom, {$urandom, tag},
                pick_word());
   endtask

   // Reply side: draws a stall per reply word, and keeps the stimulus
   // informed of tags handed out.
   always @(posedge clock) begin : reply_side
      int n;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         case (rsp_status)
            ST_ALLOCATED: begin
               live_tags.insert(live_tags.size(), rsp_tag);
               seen_alloc[rsp_slot_out] = 1'b1;
               n_alloc++;
            end
            ST_EMPTY:     n_empty++;
            ST_DELIVERED: n_delivered++;
            ST_STALE:     n_stale++;
            ST_NOWAITER:  n_nowaiter++;
            ST_TIMEOUT:   n_timeout++;
            default: ;
         endcase
         n_replies++;
         if (n_replies % 64 == 0) calm_rsp = ($urandom_range(0, 3) == 0);
         n = calm_rsp ? 0 : $urandom_range(0, 15);
         rsp_stall <= (n != 0);
         rsp_hold  <= (n > 0) ? n - 1 : 0;
      end else if (rsp_stall) begin
         if (rsp_hold == 0) rsp_stall <= 1'b0;
         else rsp_hold <= rsp_hold - 1;
      end
   end

   initial begin : stimulus
      int kind;
      int pick;
      int target;
      logic [TAG_BITS-1:0] tag;

      reset            = 1'b1;
      req_valid        = 1'b0;
      req_cmd          = CMD_ALLOC;
      req_slot_index   = '0;
      req_extra_in     = '0;
      req_done_tag     = '0;
      req_result_value = '0;
      calm_req         = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. After reset the stack hands out 4095, 4094, 4093,
      // all at generation 1, so the tags are known up front.
      send_word(CMD_ALLOC, 12'd0, 32'h7FFF_FFFF, 64'd0, 32'd0);        // 0x1FFF
      send_word(CMD_ALLOC, 12'hFFF, 32'h8000_0000, 64'd0, 32'd0);      // 0x1FFE
      send_word(CMD_ALLOC, 12'd0, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);   // 0x1FFD
      // completion before anyone waits on it
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_1FFF, 32'd5);
      send_word(CMD_ARM, 12'd4095, 32'd0, 64'd0, 32'd0);
      // generation ahead of the slot
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_2FFF, 32'd1);
      // high half of the tag is ignored: this one is delivered
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'hFFFF_FFFF_0000_1FFF, 32'h8000_0000);
      // reserved timeout tag
      send_word(CMD_COMPLETE, 12'hFFF, 32'hFFFF_FFFF, '1, 32'h7FFF_FFFF);
      // low half all ones but not the timeout tag: top generation, stale
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_FFFF_FFFF, 32'd0);
      send_word(CMD_ARM, 12'd4094, 32'd0, 64'd0, 32'd0);
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_1FFE, 32'h7FFF_FFFF);
      // arm a slot never handed out, then a tag for it that cannot match
      send_word(CMD_ARM, 12'd0, 32'd0, 64'd0, 32'd0);
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_5000, 32'd0);
      // generation zero on a slot already in use
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_0FFD, 32'd0);
      send_word(CMD_ARM, 12'd4093, 32'd0, 64'd0, 32'd0);
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_1FFD, 32'hFFFF_FFFF);
      // pool is full again; re-arm the free slot and complete it once more,
      // so the push back onto the stack is lost
      send_word(CMD_ARM, 12'd4093, 32'd0, 64'd0, 32'd0);
      send_word(CMD_COMPLETE, 12'd0, 32'd0, 64'h0000_0000_0000_1FFD, 32'd3);
      send_word(CMD_NONE, 12'hFFF, 32'hFFFF_FFFF, '1, 32'hFFFF_FFFF);
      send_word(CMD_ALLOC, 12'd0, 32'd0, 64'd0, 32'd0);
      wait_quiet();

      // Random mix: mostly allocate / arm / complete on live tags, the rest
      // stale tags, timeouts, stray arms, junk tags and the unused command.
      target = n_sent + RANDOM_WORDS;
      while (n_sent < target) begin
         kind = $urandom_range(0, 99);
         if (kind < 30 || live_tags.size() == 0) begin
            send_word(CMD_ALLOC, SLOT_BITS'($urandom), pick_word(), {$urandom, $urandom},
                      $urandom);
         end else if (kind < 55) begin
            arm_and_complete();
         end else if (kind < 65) begin
            pick = $urandom_range(0, live_tags.size() - 1);
            tag = live_tags[pick];
            send_word(CMD_ARM, tag[SLOT_BITS-1:0], $urandom, {$urandom, $urandom}, $urandom);
         end else if (kind < 75) begin
            pick = $urandom_range(0, live_tags.size() - 1);
            tag = live_tags[pick];
            if ($urandom_range(0, 1) == 0) live_tags.delete(pick);
            send_word(CMD_COMPLETE, SLOT_BITS'($urandom), $urandom, {$urandom, tag},
                      pick_word());
         end else if (kind < 83) begin
            pick = $urandom_range(0, live_tags.size() - 1);
            tag = live_tags[pick];
            tag[TAG_BITS-1:SLOT_BITS] = tag[TAG_BITS-1:SLOT_BITS] ^
                                        GEN_BITS'($urandom_range(1, (1 << GEN_BITS) - 1));
            send_word(CMD_COMPLETE, SLOT_BITS'($urandom), $urandom,
                      safe_tag({$urandom, tag}), pick_word());
         end else if (kind < 88) begin
            send_word(CMD_COMPLETE, SLOT_BITS'($urandom), $urandom, '1, $urandom);
         end else if (kind < 94) begin
            send_word(CMD_COMPLETE, SLOT_BITS'($urandom), $urandom,
                      safe_tag({$urandom, $urandom}), $urandom);
         end else if (kind < 97) begin
            send_word(CMD_ARM, SLOT_BITS'($urandom), $urandom, {$urandom, $urandom}, $urandom);
         end else if (kind < 99) begin
            send_word(CMD_NONE, SLOT_BITS'($urandom), $urandom, {$urandom, $urandom},
                      $urandom);
         end else begin
            wait_quiet();
         end
      end

      wait_quiet();
      // leave room for any stray reply
      repeat (20) @(posedge clock);

      $display("Sent %0d request words; %0d reply words checked.",
               n_sent, replies_checked);
      $display("Replies: %0d allocated, %0d pool empty, %0d delivered, %0d stale, %0d no waiter, %0d timeout.",
               n_alloc, n_empty, n_delivered, n_stale, n_nowaiter, n_timeout);
      if (fail_count == 0 && pending_replies == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
